@@ src/assert_macros.svh @@
// Assertion macros for the port level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted
`define PTS_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("scheduler check failed");

// Concurrent check that also holds during reset
`define PTS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scheduler check failed during or after reset");

`endif

@@ src/pts_pkg.sv @@
// Package for the periodic task scheduler: constants, codes and shared types
`default_nettype none

package pts_pkg;

    // Default sizing handed to the top level parameters
    localparam int NUM_TASKS_DEF = 4;
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;
    localparam int OUT_TIME_BITS = 32;
    localparam int TASK_BITS     = 3;
    localparam int ACTIVE_BITS   = 3;
    localparam int PERIOD_BITS   = 16;
    localparam int BUDGET_BITS   = 16;

    // Number of timing registers in the register map
    localparam int TIMING_REGS = 4;

    // Register map
    localparam logic [CFG_IDX_BITS-1:0] REG_POLICY  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE  = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMING0 = 8'd2;

    // Reset value of the active task count
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd4;

    // Scheduling policy codes
    localparam logic POLICY_RM  = 1'b0;
    localparam logic POLICY_EDF = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHARGE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // tick accepted: clear on restart, rewind the scan
        logic scan;    // release and rank the current slot
        logic charge;  // charge the winner, register the result, advance time
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last;     // current slot is the last enabled one
        logic none_enabled;  // no slot enabled, skip the scan
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/pts_ctrl.sv @@
// Controller of the periodic task scheduler: tick sequencing and output handshake
`default_nettype none

module pts_ctrl
    import pts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic     i_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // Output slot can take a new beat when empty or being drained
    assign w_out_free = !r_out_valid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_stat.none_enabled ? ST_CHARGE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_CHARGE;
                end
            end
            ST_CHARGE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_CHARGE: begin
                o_cmd.charge = w_out_free;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ src/pts_dp.sv @@
// Datapath of the periodic task scheduler: registers, task state, scan and result
`default_nettype none

module pts_dp
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_restart,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    output logic [OUT_TIME_BITS-1:0]      o_tick_time,
    output logic [TASK_BITS-1:0]          o_running_task,
    output logic [OUT_TIME_BITS-1:0]      o_running_deadline
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);

    // Configuration registers
    logic                     r_mode;
    logic [ACTIVE_BITS-1:0]   r_active;
    logic [CFG_DATA_BITS-1:0] r_timing [NUM_TASKS];

    // Run state
    logic [TIME_BITS-1:0]   r_time;
    logic [BUDGET_BITS-1:0] r_budget [NUM_TASKS];
    logic [TIME_BITS-1:0]   r_next   [NUM_TASKS];
    logic [TIME_BITS-1:0]   r_dl     [NUM_TASKS];

    // Scan and winner tracking
    logic [IDX_W-1:0]     r_idx;
    logic                 r_win_valid;
    logic [IDX_W-1:0]     r_win_idx;
    logic [TIME_BITS-1:0] r_best;

    // Result registers
    logic [OUT_TIME_BITS-1:0] r_o_time;
    logic [TASK_BITS-1:0]     r_o_task;
    logic [OUT_TIME_BITS-1:0] r_o_dl;

    logic [CNT_W-1:0]       w_enabled;
    logic [TIME_BITS-1:0]   w_period;
    logic [BUDGET_BITS-1:0] w_burst;
    logic                   w_rel;
    logic [TIME_BITS-1:0]   w_rel_sum;
    logic [TIME_BITS-1:0]   w_next;
    logic [BUDGET_BITS-1:0] w_budget;
    logic [TIME_BITS-1:0]   w_dl;
    logic [TIME_BITS-1:0]   w_key;
    logic                   w_take;
    logic [IDX_W:0]         w_task_num;

    // Saturate the active count to the slots present
    always_comb begin
        if (int'(r_active) > NUM_TASKS) begin
            w_enabled = CNT_W'(NUM_TASKS);
        end else begin
            w_enabled = CNT_W'(r_active);
        end
    end

    assign o_stat.none_enabled = (w_enabled == '0);
    assign o_stat.scan_last    = ((CNT_W'(r_idx) + CNT_W'(1)) == w_enabled);

    // Release and rank the slot under scan
    assign w_period  = TIME_BITS'(r_timing[r_idx][PERIOD_BITS-1:0]);
    assign w_burst   = r_timing[r_idx][CFG_DATA_BITS-1:PERIOD_BITS];
    assign w_rel     = (r_next[r_idx] == r_time);
    assign w_rel_sum = r_time + w_period;
    assign w_next    = w_rel ? w_rel_sum : r_next[r_idx];
    assign w_budget  = w_rel ? w_burst : r_budget[r_idx];
    assign w_dl      = w_rel ? w_rel_sum : r_dl[r_idx];

    // A fresh release sits exactly one period from now
    always_comb begin
        if (r_mode == POLICY_EDF && !w_rel) begin
            w_key = r_dl[r_idx] - r_time;
        end else begin
            w_key = w_period;
        end
    end

    // Strict compare keeps the lowest numbered slot on ties
    assign w_take = (w_budget != '0) && (!r_win_valid || (w_key < r_best));

    assign w_task_num = {1'b0, r_win_idx} + (IDX_W + 1)'(1);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= POLICY_RM;
            r_active <= ACTIVE_RESET;
            for (int j = 0; j < NUM_TASKS; j++) begin
                r_timing[j] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_POLICY) begin
                r_mode <= i_cfg_data[0];
            end
            if (i_cfg_index == REG_ACTIVE) begin
                r_active <= i_cfg_data[ACTIVE_BITS-1:0];
            end
            for (int j = 0; j < NUM_TASKS; j++) begin
                if (j < TIMING_REGS &&
                    i_cfg_index == REG_TIMING0 + CFG_IDX_BITS'(j)) begin
                    r_timing[j] <= i_cfg_data;
                end
            end
        end
    end

    // Task state: clear on restart, update at scan, charge the winner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            for (int j = 0; j < NUM_TASKS; j++) begin
                r_budget[j] <= '0;
                r_next[j]   <= '0;
                r_dl[j]     <= '0;
            end
        end else begin
            if (i_cmd.load && i_restart) begin
                r_time <= '0;
            end else if (i_cmd.charge) begin
                r_time <= r_time + TIME_BITS'(1);
            end
            for (int j = 0; j < NUM_TASKS; j++) begin
                if (i_cmd.load && i_restart) begin
                    r_budget[j] <= '0;
                    r_next[j]   <= '0;
                    r_dl[j]     <= '0;
                end else if (i_cmd.scan && r_idx == IDX_W'(j)) begin
                    r_budget[j] <= w_budget;
                    r_next[j]   <= w_next;
                    r_dl[j]     <= w_dl;
                end else if (i_cmd.charge && r_win_valid && r_win_idx == IDX_W'(j)) begin
                    r_budget[j] <= r_budget[j] - BUDGET_BITS'(1);
                end
            end
        end
    end

    // Scan pointer and winner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_win_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx       <= '0;
            r_win_valid <= 1'b0;
        end else if (i_cmd.scan) begin
            if (!o_stat.scan_last) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_take) begin
                r_win_valid <= 1'b1;
            end
        end
    end

    // Winner payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && w_take) begin
            r_win_idx <= r_idx;
            r_best    <= w_key;
        end
    end

    // Result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.charge) begin
            r_o_time <= OUT_TIME_BITS'(r_time);
            if (r_win_valid) begin
                r_o_task <= TASK_BITS'(w_task_num);
                r_o_dl   <= (r_mode == POLICY_EDF) ?
                            OUT_TIME_BITS'(r_dl[r_win_idx]) : '0;
            end else begin
                r_o_task <= '0;
                r_o_dl   <= '0;
            end
        end
    end

    assign o_tick_time        = r_o_time;
    assign o_running_task     = r_o_task;
    assign o_running_deadline = r_o_dl;

endmodule

`default_nettype wire

@@ src/periodic_task_scheduler.sv @@
// Top level of the periodic task scheduler (rate monotonic or earliest deadline first)
//
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+---------------------------
//  tick in  | i_valid, o_stall, i_restart                | beat when valid and !stall
//  result   | o_valid, i_stall, o_tick_time,             | beat when valid and !stall
//           | o_running_task, o_running_deadline         |
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index,     | write when valid and ready
//           | i_cfg_data                                 |
//
// A tick is accepted in the idle state, then each enabled task slot is released and
// ranked in the scan state (one slot per cycle through a single compare unit), and
// the charge state charges the winner and loads the result register.
// The next tick is accepted while the result still waits; a held result
// delays only the charge cycle of the tick after it.
// Synchronous reset clears all but winner and result registers; no clearing pass.
`default_nettype none

module periodic_task_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_restart,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [OUT_TIME_BITS-1:0]      o_tick_time,
    output logic [TASK_BITS-1:0]          o_running_task,
    output logic [OUT_TIME_BITS-1:0]      o_running_deadline,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall     (i_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    pts_dp #(
        .NUM_TASKS (NUM_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_restart          (i_restart),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_tick_time        (o_tick_time),
        .o_running_task     (o_running_task),
        .o_running_deadline (o_running_deadline)
    );

endmodule

`default_nettype wire

@@ src/pts_checker.sv @@
// Port level checks for the periodic task scheduler and their bind
`default_nettype none

`include "assert_macros.svh"

module pts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_tick_time,
    input wire logic [2:0]  o_running_task,
    input wire logic [31:0] o_running_deadline
);

    // Hold a stalled result beat
    `PTS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    `PTS_ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_tick_time))

    // Idle ticks carry no deadline
    `PTS_ASSERT_RST(a_idle_dl, i_clk, i_rst_n,
                    o_valid && o_running_task == 3'd0 |-> o_running_deadline == 32'd0)

    // A tick in work blocks the next one
    `PTS_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)

    // Reset drops any pending result
    `PTS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_tick_time        (o_tick_time),
    .o_running_task     (o_running_task),
    .o_running_deadline (o_running_deadline)
);

`default_nettype wire

@@ tb/pts_schedule_checker.sv @@
// Scheduler checker: snoops the register writes and ticks, predicts each result and compares
module pts_schedule_checker
    import pts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_tick_valid,
    input  logic                     i_tick_stall,
    input  logic                     i_restart,
    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic [OUT_TIME_BITS-1:0] i_tick_time,
    input  logic [TASK_BITS-1:0]     i_running_task,
    input  logic [OUT_TIME_BITS-1:0] i_running_deadline,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_W = (NUM_TASKS_DEF > 1) ? $clog2(NUM_TASKS_DEF) : 1;

    typedef struct packed {
        logic [OUT_TIME_BITS-1:0] tick_time;
        logic [TASK_BITS-1:0]     task_no;
        logic [OUT_TIME_BITS-1:0] deadline;
    } t_tick_result;

    // Shadow of the register file
    logic                     policy;
    logic [ACTIVE_BITS-1:0]   act_count;
    logic [CFG_DATA_BITS-1:0] timing [NUM_TASKS_DEF];

    // Shadow of the run state
    logic [TIME_BITS_DEF-1:0] now_time;
    logic [BUDGET_BITS-1:0]   budget [NUM_TASKS_DEF];
    logic [TIME_BITS_DEF-1:0] next_rel [NUM_TASKS_DEF];
    logic [TIME_BITS_DEF-1:0] deadline [NUM_TASKS_DEF];

    t_tick_result expected_ticks [$];
    int           fails = 0;

    function automatic void clear_run();
        now_time = '0;
        for (int k = 0; k < NUM_TASKS_DEF; k++) begin
            budget[k] = '0;
            next_rel[k] = '0;
            deadline[k] = '0;
        end
    endfunction

    // Release due tasks, pick the winner, charge it and advance time
    function automatic t_tick_result schedule_tick(input logic clear_first);
        t_tick_result             res;
        logic [TIME_BITS_DEF-1:0] t;
        logic [TIME_BITS_DEF-1:0] key;
        logic [TIME_BITS_DEF-1:0] best;
        logic [TIME_BITS_DEF-1:0] per;
        int                       n_on;
        int                       win;
        if (clear_first) clear_run();
        t = now_time;
        n_on = (act_count > NUM_TASKS_DEF) ? NUM_TASKS_DEF : int'(act_count);
        win = -1;
        best = '0;
        for (int k = 0; k < n_on; k++) begin
            per = TIME_BITS_DEF'(timing[k][PERIOD_BITS-1:0]);
            if (next_rel[k] == t) begin
                budget[k] = timing[k][PERIOD_BITS+BUDGET_BITS-1:PERIOD_BITS];
                deadline[k] = t + per;
                next_rel[k] = next_rel[k] + per;
            end
        end
        // ties go to the lowest slot: only a strictly smaller key replaces
        for (int k = 0; k < n_on; k++) begin
            if (budget[k] != '0) begin
                if (policy == POLICY_EDF) key = deadline[k] - t;
                else key = TIME_BITS_DEF'(timing[k][PERIOD_BITS-1:0]);
                if (win < 0 || key < best) begin
                    win = k;
                    best = key;
                end
            end
        end
        res.tick_time = OUT_TIME_BITS'(t);
        res.task_no = '0;
        res.deadline = '0;
        if (win >= 0) begin
            budget[win] = budget[win] - BUDGET_BITS'(1);
            res.task_no = TASK_BITS'(win + 1);
            if (policy == POLICY_EDF) res.deadline = OUT_TIME_BITS'(deadline[win]);
        end
        now_time = t + TIME_BITS_DEF'(1);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            policy = POLICY_RM;
            act_count = ACTIVE_RESET;
            for (int k = 0; k < NUM_TASKS_DEF; k++) timing[k] = '0;
            clear_run();
            expected_ticks.delete();
        end else begin
            // track register writes; unmapped indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_POLICY) begin
                    policy = i_cfg_data[0];
                end else if (i_cfg_index == REG_ACTIVE) begin
                    act_count = i_cfg_data[ACTIVE_BITS-1:0];
                end else if (i_cfg_index >= REG_TIMING0 &&
                             i_cfg_index < REG_TIMING0 + CFG_IDX_BITS'(TIMING_REGS)) begin
                    timing[SLOT_W'(i_cfg_index - REG_TIMING0)] = i_cfg_data;
                end
            end

            // compare the result beat with the oldest prediction
            if (i_res_valid && !i_res_stall) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: result beat with nothing expected: time %0d task %0d deadline %0d",
                             $time, i_tick_time, i_running_task, i_running_deadline);
                    fails++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (i_tick_time !== want.tick_time) begin
                        $display("%0t: tick_time expected %0d, got %0d",
                                 $time, want.tick_time, i_tick_time);
                        fails++;
                    end
                    if (i_running_task !== want.task_no) begin
                        $display("%0t: running_task at time %0d expected %0d, got %0d",
                                 $time, want.tick_time, want.task_no, i_running_task);
                        fails++;
                    end
                    if (i_running_deadline !== want.deadline) begin
                        $display("%0t: running_deadline at time %0d expected %0d, got %0d",
                                 $time, want.tick_time, want.deadline, i_running_deadline);
                        fails++;
                    end
                end
            end

            // predict the tick beat
            if (i_tick_valid && !i_tick_stall)
                expected_ticks.push_back(schedule_tick(i_restart));
        end
        o_fail_count <= fails;
        o_pending <= expected_ticks.size();
    end

endmodule

@@ tb/tb_periodic_task_scheduler.sv @@
// Testbench top: drives ticks and register writes into the scheduler and gives the verdict
module tb_periodic_task_scheduler
    import pts_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_TICKS    = 1750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 38;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_restart = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [OUT_TIME_BITS-1:0] o_tick_time;
    logic [TASK_BITS-1:0]     o_running_task;
    logic [OUT_TIME_BITS-1:0] o_running_deadline;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int   fail_count;
    int   pending_ticks;
    int   tick_count = 0;
    int   quiet_cycles = 0;
    logic steady = 1'b0;

    periodic_task_scheduler u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_restart          (i_restart),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_tick_time        (o_tick_time),
        .o_running_task     (o_running_task),
        .o_running_deadline (o_running_deadline),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    pts_schedule_checker u_schedule_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_tick_valid       (i_valid),
        .i_tick_stall       (o_stall),
        .i_restart          (i_restart),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_tick_time        (o_tick_time),
        .i_running_task     (o_running_task),
        .i_running_deadline (o_running_deadline),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending_ticks)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result side at random, never during the steady stretch
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: end the run when no beat moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL periodic_task_scheduler");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one tick beat, with random idle cycles ahead of it; valid stays high on return
    task automatic send_tick(input logic clear_first);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            i_restart <= 1'($urandom);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_restart <= clear_first;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tick_count++;
    endtask

    // Write one register; cfg valid is left high for the next write
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Drop tick valid and wait until every result is out and the block has settled
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_ticks != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_BITS-1:0] data;
        logic [ACTIVE_BITS-1:0]   act;
        logic                     first_clear;
        int                       len;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero period and zero burst on all slots, every tick idle
        send_tick(1'b0);
        send_tick(1'b1);

        // rate monotonic with mixed periods, a maximal slot and an unmapped write
        quiesce();
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_RM));
        write_reg(REG_ACTIVE, CFG_DATA_BITS'(ACTIVE_RESET));
        write_reg(REG_TIMING0, {16'd2, 16'd4});
        write_reg(CFG_IDX_BITS'(REG_TIMING0 + 1), {16'd1, 16'd2});
        write_reg(CFG_IDX_BITS'(REG_TIMING0 + 2), '1);
        write_reg(CFG_IDX_BITS'(REG_TIMING0 + 3), '0);
        write_reg(CFG_IDX_BITS'(REG_TIMING0 + TIMING_REGS), '1);
        write_reg('1, '1);
        i_cfg_valid <= 1'b0;
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);

        // earliest deadline first, active count above the slot count saturates
        quiesce();
        write_reg(REG_POLICY, '1);
        write_reg(REG_ACTIVE, '1);
        write_reg(CFG_IDX_BITS'(REG_TIMING0 + 3), '1);
        i_cfg_valid <= 1'b0;
        repeat (5) send_tick(1'b0);

        // no slot enabled
        quiesce();
        write_reg(REG_ACTIVE, '0);
        i_cfg_valid <= 1'b0;
        repeat (3) send_tick(1'b0);

        // two slots, zero period task released only on the first tick after restart
        quiesce();
        write_reg(REG_ACTIVE, CFG_DATA_BITS'(2));
        write_reg(REG_TIMING0, {16'd3, 16'd0});
        i_cfg_valid <= 1'b0;
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // random phases: new settings between phases, mostly small periods and bursts
        while (tick_count < TOTAL_TICKS) begin
            quiesce();
            write_reg(REG_POLICY, $urandom);
            act = ($urandom_range(0, 9) < 8) ? ACTIVE_BITS'($urandom_range(1, 4))
                                             : ACTIVE_BITS'($urandom_range(0, 7));
            data = $urandom;
            data[ACTIVE_BITS-1:0] = act;
            write_reg(REG_ACTIVE, data);
            for (int k = 0; k < TIMING_REGS; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0: data = $urandom;
                        1: data = {16'($urandom_range(1, 3)), 16'h0000};
                        2: data = {16'h0000, 16'($urandom_range(1, 8))};
                        default: data = {16'($urandom_range(1, 4)), 16'($urandom_range(1, 12))};
                    endcase
                    write_reg(CFG_IDX_BITS'(REG_TIMING0 + k), data);
                end
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_BITS'($urandom_range(REG_TIMING0 + TIMING_REGS,
                                                       (1 << CFG_IDX_BITS) - 1)), $urandom);
            i_cfg_valid <= 1'b0;

            len = $urandom_range(10, 60);
            first_clear = 1'($urandom_range(0, 1));
            for (int n = 0; n < len; n++) begin
                steady <= (tick_count >= 600 && tick_count < 900);
                send_tick((n == 0) ? first_clear : ($urandom_range(0, 99) < 3));
            end
        end

        steady <= 1'b0;
        quiesce();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_ticks == 0) begin
            $display("PASS periodic_task_scheduler");
        end else begin
            $display("FAIL periodic_task_scheduler");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/pts_pkg.sv
src/pts_ctrl.sv
src/pts_dp.sv
src/periodic_task_scheduler.sv
src/pts_checker.sv
tb/pts_schedule_checker.sv
tb/tb_periodic_task_scheduler.sv
